FILE: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, opcodes and the saturating clamp of the Q-format ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int OP_BITS   = 4;
    localparam int DATA_BITS = 32;
    localparam int FRAC_W    = 5;
    localparam int FRAC_MAX  = 16;
    localparam int FRAC_RST  = 8;
    localparam int X_BITS    = 66;             // exact intermediate width
    localparam int N_BITS    = DATA_BITS + FRAC_MAX;   // divider numerator
    localparam int Q_BITS    = N_BITS + 1;             // rounded quotient
    localparam int DIV_STEP  = 2;              // quotient bits per stage
    localparam int DIV_STAGES = N_BITS / DIV_STEP;
    localparam int DIV_LAT   = DIV_STAGES + 1;
    localparam int MUL_LAT   = 3;

    localparam logic [OP_BITS-1:0] OP_ADD  = 4'd0;
    localparam logic [OP_BITS-1:0] OP_SUB  = 4'd1;
    localparam logic [OP_BITS-1:0] OP_MUL  = 4'd2;
    localparam logic [OP_BITS-1:0] OP_DIV  = 4'd3;
    localparam logic [OP_BITS-1:0] OP_MIN  = 4'd4;
    localparam logic [OP_BITS-1:0] OP_MAX  = 4'd5;
    localparam logic [OP_BITS-1:0] OP_ABS  = 4'd6;
    localparam logic [OP_BITS-1:0] OP_INC  = 4'd7;
    localparam logic [OP_BITS-1:0] OP_DEC  = 4'd8;
    localparam logic [OP_BITS-1:0] OP_TOI  = 4'd9;
    localparam logic [OP_BITS-1:0] OP_FRI  = 4'd10;
    localparam logic [OP_BITS-1:0] OP_CMP  = 4'd11;

    typedef struct packed {
        logic [DATA_BITS-1:0] res;
        logic                 sat;
    } t_sres;

    // Side information that travels alongside the divider
    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic                 lt;
        logic                 eq;
        logic                 gt;
        logic                 neg;
        logic                 a_pos;
        logic                 a_neg;
        logic                 b_zero;
        logic [DATA_BITS-1:0] res;
        logic                 sat;
    } t_side;

    function automatic t_sres sat_clamp(input logic signed [X_BITS-1:0] x, input int wb);
        logic signed [X_BITS-1:0] hi;
        logic signed [X_BITS-1:0] lo;
        t_sres s;
        hi = signed'(X_BITS'(1) << (wb - 1)) - signed'(X_BITS'(1));
        lo = -hi - signed'(X_BITS'(1));
        s.sat = 1'b0;
        if (x > hi) begin
            s.res = hi[DATA_BITS-1:0];
            s.sat = 1'b1;
        end else if (x < lo) begin
            s.res = lo[DATA_BITS-1:0];
            s.sat = 1'b1;
        end else begin
            s.res = x[DATA_BITS-1:0];
        end
        return s;
    endfunction

endpackage

FILE: rtl/fixed_point_alu_q24_8_core.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_core
// Signed fixed-point ALU with saturation, rounding multiply and divide.
// ----------------------------------------------------------------------------
// Items arrive on the s-side stream: tdata holds op, operand_a, operand_b.
// Results leave on the m-side stream: result plus less, equal, greater,
// saturated and divide_by_zero flags. One result per accepted item, in order.
// Throughput: one transfer per cycle while o_s_tready is high. The input
// register loads at the transfer edge, then the 24-stage divider (two
// quotient bits per stage), its rounding stage and the output register
// follow; the output register raises o_m_tvalid. Every opcode
// takes the same path length so order is kept.
// The whole pipeline advances as one; when the receiver holds tready low
// with a result waiting, all stages hold and o_s_tready falls.
// frac_bits is written through i_cfg_we / i_cfg_wdata, by the user only
// while idle; the block does not enforce this. Values above 16 act as 16.
// Reset (synchronous, active low) empties the pipeline and sets frac_bits to 8.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8_core
    import fpa_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // op[3:0], operand_a[35:4], operand_b[67:36]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // result[31:0], less, equal, greater,
                                     // saturated, divide_by_zero [36:32]
);

    // clamp limits of the word, low bits give the divide-by-zero results
    localparam logic [X_BITS-1:0] W_HI = (X_BITS'(1) << (WORD_BITS - 1)) - X_BITS'(1);
    localparam logic [X_BITS-1:0] W_LO = ~W_HI;

    logic [FRAC_W-1:0]           r_frac;
    logic                        en;
    logic                        r_v0;
    logic [DIV_LAT-1:0]          r_vp;
    logic                        r_out_v;
    logic [OP_BITS-1:0]          r_op;
    logic signed [DATA_BITS-1:0] r_a, r_b;
    logic [FRAC_W-1:0]           r_f;
    logic [39:0]                 r_out;
    logic [39:0]                 n_out;

    logic signed [X_BITS-1:0]    ax, bx, fx;
    logic [DATA_BITS-1:0]        ma, mb;
    logic [FRAC_W-1:0]           f;
    t_side                       side, side_d;
    t_sres                       mul_r, mul_d, fin;
    logic [Q_BITS-1:0]           q;
    logic [$bits(t_side)-1:0]    side_q;
    logic [$bits(t_sres)-1:0]    mul_q;

    assign en         = !r_out_v || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= FRAC_W'(FRAC_RST);
        end else if (i_cfg_we) begin
            r_frac <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_vp    <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v0    <= i_s_tvalid;
            r_vp    <= {r_vp[DIV_LAT-2:0], r_v0};
            r_out_v <= r_vp[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op <= i_s_tdata[3:0];
            r_a  <= i_s_tdata[35:4];
            r_b  <= i_s_tdata[67:36];
            r_f  <= (r_frac > FRAC_W'(FRAC_MAX)) ? FRAC_W'(FRAC_MAX) : r_frac;
        end
    end

    // decode and the combinational operations
    always_comb begin
        f  = r_f;
        ax = X_BITS'(r_a);
        bx = X_BITS'(r_b);
        ma = r_a[DATA_BITS-1] ? (~r_a + 1'b1) : r_a;
        mb = r_b[DATA_BITS-1] ? (~r_b + 1'b1) : r_b;
        fx = signed'(X_BITS'(ma) << f);

        side.op     = r_op;
        side.lt     = r_a < r_b;
        side.eq     = r_a == r_b;
        side.gt     = r_a > r_b;
        side.neg    = r_a[DATA_BITS-1] ^ r_b[DATA_BITS-1];
        side.a_pos  = !r_a[DATA_BITS-1] && (r_a != '0);
        side.a_neg  = r_a[DATA_BITS-1];
        side.b_zero = r_b == '0;
        side.res    = '0;
        side.sat    = 1'b0;
        case (r_op)
            OP_ADD: {side.res, side.sat} = sat_clamp(ax + bx, WORD_BITS);
            OP_SUB: {side.res, side.sat} = sat_clamp(ax - bx, WORD_BITS);
            OP_ABS: {side.res, side.sat} = sat_clamp(r_a[DATA_BITS-1] ? -ax : ax,
                                                     WORD_BITS);
            OP_INC: {side.res, side.sat} = sat_clamp(ax + X_BITS'(1), WORD_BITS);
            OP_DEC: {side.res, side.sat} = sat_clamp(ax - X_BITS'(1), WORD_BITS);
            OP_FRI: {side.res, side.sat} = sat_clamp(r_a[DATA_BITS-1] ? -fx : fx,
                                                     WORD_BITS);
            OP_TOI: side.res = r_a >>> f;
            OP_MIN: side.res = (r_a < r_b) ? r_a : r_b;
            OP_MAX: side.res = (r_a > r_b) ? r_a : r_b;
            default: side.res = '0;
        endcase
    end

    fpa_mul #(.WORD_BITS(WORD_BITS)) u_mul (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ma   (ma),
        .i_mb   (mb),
        .i_neg  (side.neg),
        .i_frac (f),
        .o_res  (mul_r)
    );

    fpa_dly #(.WIDTH($bits(t_sres)), .DEPTH(DIV_LAT - MUL_LAT)) u_mul_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (mul_r),
        .o_q   (mul_q)
    );

    fpa_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_n   (N_BITS'(ma) << f),
        .i_d   (mb),
        .o_q   (q)
    );

    fpa_dly #(.WIDTH($bits(t_side)), .DEPTH(DIV_LAT)) u_side_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (side),
        .o_q   (side_q)
    );

    assign side_d = t_side'(side_q);
    assign mul_d  = t_sres'(mul_q);

    // final selection
    always_comb begin
        logic dz;
        dz  = 1'b0;
        fin.res = side_d.res;
        fin.sat = side_d.sat;
        case (side_d.op)
            OP_MUL: fin = mul_d;
            OP_DIV: begin
                if (side_d.b_zero) begin
                    dz      = 1'b1;
                    fin.sat = 1'b0;
                    if (side_d.a_pos) begin
                        fin.res = W_HI[DATA_BITS-1:0];
                    end else if (side_d.a_neg) begin
                        fin.res = W_LO[DATA_BITS-1:0];
                    end else begin
                        fin.res = '0;
                    end
                end else begin
                    fin = sat_clamp(side_d.neg ? -signed'(X_BITS'(q))
                                               : signed'(X_BITS'(q)), WORD_BITS);
                end
            end
            default: ;
        endcase
        n_out = {3'b0, dz, fin.sat, side_d.gt, side_d.eq, side_d.lt, fin.res};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: rtl/fpa_dly.sv
// ----------------------------------------------------------------------------
// fpa_dly
// Enabled register delay line for payload alignment.
// ----------------------------------------------------------------------------
module fpa_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_q [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[DEPTH-1];

endmodule

FILE: rtl/fpa_mul.sv
// ----------------------------------------------------------------------------
// fpa_mul
// Three-stage multiplier: product, round half away from zero, clamp.
// ----------------------------------------------------------------------------
module fpa_mul
    import fpa_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [DATA_BITS-1:0] i_ma,
    input  logic [DATA_BITS-1:0] i_mb,
    input  logic                 i_neg,
    input  logic [FRAC_W-1:0]    i_frac,
    output t_sres                o_res
);

    logic [2*DATA_BITS-1:0] r_p, r_m, n_m, half;
    logic                   r_neg1, r_neg2;
    logic [FRAC_W-1:0]      r_f1;
    t_sres                  r_out;
    logic signed [X_BITS-1:0] x;

    always_comb begin
        half = (r_f1 == '0) ? '0 : ((2*DATA_BITS)'(1) << (r_f1 - FRAC_W'(1)));
        n_m  = (r_p + half) >> r_f1;
        x    = r_neg2 ? -signed'(X_BITS'(r_m)) : signed'(X_BITS'(r_m));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= (2*DATA_BITS)'(i_ma) * (2*DATA_BITS)'(i_mb);
            r_neg1 <= i_neg;
            r_f1   <= i_frac;
            r_m    <= n_m;
            r_neg2 <= r_neg1;
            r_out  <= sat_clamp(x, WORD_BITS);
        end
    end

    assign o_res = r_out;

endmodule

FILE: rtl/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, two quotient bits per stage, then rounding.
// ----------------------------------------------------------------------------
module fpa_div
    import fpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [N_BITS-1:0]    i_n,
    input  logic [DATA_BITS-1:0] i_d,
    output logic [Q_BITS-1:0]    o_q
);

    logic [DATA_BITS:0]   r_rem [DIV_STAGES];
    logic [N_BITS-1:0]    r_nq  [DIV_STAGES];
    logic [DATA_BITS-1:0] r_d   [DIV_STAGES];
    logic [DATA_BITS:0]   n_rem [DIV_STAGES];
    logic [N_BITS-1:0]    n_nq  [DIV_STAGES];
    logic [DATA_BITS:0]   s_rem [DIV_STAGES];
    logic [N_BITS-1:0]    s_nq  [DIV_STAGES];
    logic [DATA_BITS-1:0] s_d   [DIV_STAGES];
    logic [Q_BITS-1:0]    r_q;
    logic                 up;

    // stage inputs: the first stage takes the operands, the rest the previous stage
    always_comb begin
        s_rem[0] = '0;
        s_nq[0]  = i_n;
        s_d[0]   = i_d;
        for (int s = 1; s < DIV_STAGES; s++) begin
            s_rem[s] = r_rem[s-1];
            s_nq[s]  = r_nq[s-1];
            s_d[s]   = r_d[s-1];
        end
    end

    always_comb begin
        logic [DATA_BITS:0]   rem;
        logic [N_BITS-1:0]    nq;
        logic [DATA_BITS-1:0] d;
        for (int s = 0; s < DIV_STAGES; s++) begin
            rem = s_rem[s];
            nq  = s_nq[s];
            d   = s_d[s];
            for (int k = 0; k < DIV_STEP; k++) begin
                rem = {rem[DATA_BITS-1:0], nq[N_BITS-1]};
                nq  = {nq[N_BITS-2:0], 1'b0};
                if (rem >= {1'b0, d}) begin
                    rem   = rem - {1'b0, d};
                    nq[0] = 1'b1;
                end
            end
            n_rem[s] = rem;
            n_nq[s]  = nq;
        end
    end

    // round up when twice the remainder reaches the divisor
    assign up = {r_rem[DIV_STAGES-1], 1'b0} >= {2'b0, r_d[DIV_STAGES-1]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_nq[s]  <= n_nq[s];
                r_d[s]   <= s_d[s];
            end
            r_q <= Q_BITS'(r_nq[DIV_STAGES-1]) + Q_BITS'(up);
        end
    end

    assign o_q = r_q;

endmodule
